[design/masked_multi_pattern_counter_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the masked multi-pattern counter
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef MASKED_MULTI_PATTERN_COUNTER_DEFINES_SVH
`define MASKED_MULTI_PATTERN_COUNTER_DEFINES_SVH

// Same-cycle implication.
`define MMPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mmpc assertion failed");

// Next-cycle implication.
`define MMPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mmpc assertion failed");

`endif

[design/mmpc_pkg.sv]
// ---------------------------------------------------------------------------
// Masked multi-pattern counter package
// Request codes, sequencer states and the compare-unit control word.
// ---------------------------------------------------------------------------
package mmpc_pkg;

    localparam int TOTAL_W = 32;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef enum logic [1:0] {
        REQ_WRITE_BYTE  = 2'd0,
        REQ_SET_LENGTH  = 2'd1,
        REQ_BUFFER_BYTE = 2'd2
    } req_type_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic valid;
        logic clear;
    } mmpc_cmp_ctl_t;

endpackage

[design/masked_multi_pattern_counter.sv]
// ---------------------------------------------------------------------------
// Masked multi-pattern counter
// Counts masked byte pattern matches over a streamed buffer.
// ---------------------------------------------------------------------------
// Pattern write and length words finish in the cycle they are accepted, and
// the block is ready again in the next cycle. A buffer byte shifts into the
// window and then starts a scan in which one stored pattern row is read from
// the pattern memory and checked by the shared masked comparator per cycle,
// so a buffer byte keeps the block busy until its scan of all active
// patterns is done, where active is pattern_count limited to PATTERN_SLOTS.
// No new word is accepted until then; the pattern memory read port and the
// single comparator make the scan serial. On the final buffer byte the total
// moves into the output register and the window, byte count and total clear;
// the next word is accepted while that result waits, and only a second final
// byte stalls until the first is taken.
`include "masked_multi_pattern_counter_defines.svh"

module masked_multi_pattern_counter
    import mmpc_pkg::*;
#(
    parameter int PATTERN_SLOTS     = 16,
    parameter int MAX_PATTERN_BYTES = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [4:0]   cfg_wr_data,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [1:0]   req_type,
    input  logic [3:0]   pattern_index,
    input  logic [3:0]   byte_index,
    input  logic [7:0]   pattern_byte,
    input  logic         byte_cares,
    input  logic [4:0]   pattern_length,
    input  logic [7:0]   data_byte,
    input  logic         is_last,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [31:0]  match_total
);

    localparam int LW   = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int CNTW = $clog2(PATTERN_SLOTS + 1);
    localparam int PAW  = (PATTERN_SLOTS > 1) ? $clog2(PATTERN_SLOTS) : 1;
    localparam int BAW  = $clog2(MAX_PATTERN_BYTES);
    localparam int WINW = MAX_PATTERN_BYTES * 8;

    state_t                 state_reg;
    state_t                 state_next;
    logic [4:0]             pattern_count_reg;
    logic [CNTW-1:0]        active;
    logic [CNTW-1:0]        scan_idx_reg;
    logic                   last_reg;
    logic [LW-1:0]          bytes_seen_reg;
    logic [7:0]             window_reg [MAX_PATTERN_BYTES];
    logic                   out_valid_reg;
    logic [TOTAL_W-1:0]     match_total_reg;

    logic [MAX_PATTERN_BYTES-1:0][8:0] pat_mem [PATTERN_SLOTS];
    logic [LW-1:0]                     len_mem [PATTERN_SLOTS];

    logic [MAX_PATTERN_BYTES-1:0][8:0] rd_row_reg;
    logic [WINW-1:0]                   cmp_win_reg;
    logic [LW-1:0]                     cmp_len_reg;
    logic                              cmp_valid_reg;

    logic                   accept;
    logic                   wr_byte;
    logic                   wr_len;
    logic                   buf_accept;
    logic                   issue;
    logic                   done_go;
    logic [LW-1:0]          scan_len;
    logic [LW-1:0]          len_in;
    logic [WINW-1:0]        win_rev;
    logic [WINW-1:0]        win_aligned;
    logic [LW-1:0]          shift_bytes;
    mmpc_cmp_ctl_t          cmp_ctl;
    logic [TOTAL_W-1:0]     total;

    // Request decode.
    assign accept     = in_valid && in_ready;
    assign wr_byte    = accept && (req_type == REQ_WRITE_BYTE)
                        && (32'(pattern_index) < PATTERN_SLOTS)
                        && (32'(byte_index) < MAX_PATTERN_BYTES);
    assign wr_len     = accept && (req_type == REQ_SET_LENGTH)
                        && (32'(pattern_index) < PATTERN_SLOTS);
    assign buf_accept = accept && (req_type == REQ_BUFFER_BYTE);

    always_comb
    begin
        if (32'(pattern_count_reg) > PATTERN_SLOTS)
        begin
            active = CNTW'(PATTERN_SLOTS);
        end
        else
        begin
            active = CNTW'(pattern_count_reg);
        end
        if (32'(pattern_length) > MAX_PATTERN_BYTES)
        begin
            len_in = LW'(MAX_PATTERN_BYTES);
        end
        else
        begin
            len_in = LW'(pattern_length);
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (buf_accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!issue && !cmp_valid_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (done_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_ready = 1'b0;
        issue    = 1'b0;
        done_go  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_SCAN:
            begin
                issue = (scan_idx_reg < active);
            end
            ST_DONE:
            begin
                // A final byte may not overwrite a result still waiting.
                done_go = !last_reg || !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        cmp_ctl.valid = cmp_valid_reg;
        cmp_ctl.clear = done_go && last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            pattern_count_reg <= '0;
            scan_idx_reg      <= '0;
            last_reg          <= 1'b0;
            cmp_valid_reg     <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_valid_reg <= issue;
            if (cfg_wr_en)
            begin
                pattern_count_reg <= cfg_wr_data;
            end
            if (buf_accept)
            begin
                scan_idx_reg <= '0;
                last_reg     <= is_last;
            end
            else if (issue)
            begin
                scan_idx_reg <= scan_idx_reg + CNTW'(1);
            end
            if (done_go && last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_go && last_reg)
        begin
            match_total_reg <= total;
        end
    end

    // Window of recent buffer bytes; entry 0 is the newest.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_seen_reg <= '0;
            for (int i = 0; i < MAX_PATTERN_BYTES; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else if (buf_accept)
        begin
            window_reg[0] <= data_byte;
            for (int i = 1; i < MAX_PATTERN_BYTES; i++)
            begin
                window_reg[i] <= window_reg[i-1];
            end
            if (32'(bytes_seen_reg) < MAX_PATTERN_BYTES)
            begin
                bytes_seen_reg <= bytes_seen_reg + LW'(1);
            end
        end
        else if (done_go && last_reg)
        begin
            bytes_seen_reg <= '0;
            for (int i = 0; i < MAX_PATTERN_BYTES; i++)
            begin
                window_reg[i] <= '0;
            end
        end
    end

    // Pattern byte i must equal window entry len-1-i. Reversing the window
    // and shifting it down by MAX_PATTERN_BYTES-len bytes lines those up.
    always_comb
    begin
        for (int j = 0; j < MAX_PATTERN_BYTES; j++)
        begin
            win_rev[j*8 +: 8] = window_reg[MAX_PATTERN_BYTES-1-j];
        end
        scan_len    = len_mem[scan_idx_reg[PAW-1:0]];
        shift_bytes = LW'(MAX_PATTERN_BYTES) - scan_len;
        win_aligned = win_rev >> {shift_bytes, 3'b000};
    end

    always_ff @(posedge clk)
    begin
        if (wr_byte)
        begin
            pat_mem[PAW'(pattern_index)][BAW'(byte_index)] <= {byte_cares, pattern_byte};
        end
        if (issue)
        begin
            rd_row_reg <= pat_mem[scan_idx_reg[PAW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_len)
        begin
            len_mem[PAW'(pattern_index)] <= len_in;
        end
        if (issue)
        begin
            cmp_len_reg <= scan_len;
            cmp_win_reg <= win_aligned;
        end
    end

    mmpc_match_unit #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_match (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (cmp_ctl),
        .row        (rd_row_reg),
        .win        (cmp_win_reg),
        .len        (cmp_len_reg),
        .bytes_seen (bytes_seen_reg),
        .total      (total)
    );

    assign out_valid   = out_valid_reg;
    assign match_total = match_total_reg;

    `MMPC_ASSERT_IMP(a_scan_idx_bound, clk, rst_n, state_reg == ST_SCAN, scan_idx_reg <= active)
    `MMPC_ASSERT_IMP(a_cmp_in_scan, clk, rst_n, cmp_valid_reg, state_reg == ST_SCAN)
    `MMPC_ASSERT_NEXT(a_total_sat, clk, rst_n, (total == TOTAL_MAX) && !cmp_ctl.clear,
                      total == TOTAL_MAX)
    `MMPC_ASSERT_IMP(a_seen_bound, clk, rst_n, 1'b1, 32'(bytes_seen_reg) <= MAX_PATTERN_BYTES)

endmodule

[design/mmpc_match_unit.sv]
// ---------------------------------------------------------------------------
// Masked match unit
// Compares one pattern row against the aligned window and keeps the
// saturating match total.
// ---------------------------------------------------------------------------
module mmpc_match_unit
    import mmpc_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = 16,
    localparam int LW = $clog2(MAX_PATTERN_BYTES + 1)
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  mmpc_cmp_ctl_t                       ctl,
    input  logic [MAX_PATTERN_BYTES-1:0][8:0]   row,
    input  logic [MAX_PATTERN_BYTES*8-1:0]      win,
    input  logic [LW-1:0]                       len,
    input  logic [LW-1:0]                       bytes_seen,
    output logic [TOTAL_W-1:0]                  total
);

    logic [MAX_PATTERN_BYTES-1:0] lane_ok;
    logic                         hit;
    logic [TOTAL_W-1:0]           total_reg;
    logic [TOTAL_W-1:0]           total_next;

    // Lane i holds pattern byte i; the window has already been aligned so
    // that lane i faces the buffer byte it must equal.
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN_BYTES; i++)
        begin
            lane_ok[i] = (LW'(i) >= len) || !row[i][8] || (row[i][7:0] == win[i*8 +: 8]);
        end
        hit = ctl.valid && (len != '0) && (len <= bytes_seen) && (&lane_ok);
    end

    always_comb
    begin
        total_next = total_reg;
        if (ctl.clear)
        begin
            total_next = '0;
        end
        else if (hit && (total_reg != TOTAL_MAX))
        begin
            total_next = total_reg + TOTAL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else
        begin
            total_reg <= total_next;
        end
    end

    assign total = total_reg;

endmodule
